### design/cfb_pkg.sv
// Shared types, sizes and codes for the complex resonator filter bank.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package cfb_pkg;

    localparam int NUM_BINS = 64;
    localparam int BIN_W    = 6;
    // counts 0 .. NUM_BINS+1 during the bin sweep
    localparam int CNT_W    = $clog2(NUM_BINS + 2);
    // weighted phase sum: 48-bit products grown by the bin count
    localparam int ACC_W    = 48 + $clog2(NUM_BINS);
    // width after dropping 24 fraction bits from the rounded sum
    localparam int SH_W     = ACC_W - 23;

    localparam logic [15:0] LEAK_RESET = 16'd655;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_RATE   = 2'd1,
        OP_WEIGHT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } phase_t;

    typedef struct packed {
        logic signed [17:0] rate_re;
        logic signed [17:0] rate_im;
        logic signed [15:0] weight;
    } coef_t;

    // per-cycle control of the cell row
    typedef struct packed {
        logic shift;   // phases move one cell toward the head
        logic rotate;  // rates and weights circulate
    } ring_ctl_t;

    // updated bin leaving the phase pipeline
    typedef struct packed {
        logic               valid;
        logic signed [15:0] weight;
        phase_t             phase;
    } upd_t;

endpackage

`default_nettype wire

### design/cfb_if.sv
// Channel interfaces of the resonator bank: input items, results, leak gain writes.
// Depends on cfb_pkg for field widths.
`default_nettype none

interface cfb_item_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic [cfb_pkg::BIN_W-1:0] bin_index;
    logic signed [15:0]        sample_re;
    logic signed [15:0]        sample_im;
    logic signed [17:0]        rate_re;
    logic signed [17:0]        rate_im;
    logic signed [15:0]        weight;

    modport source (
        output valid, operation, bin_index, sample_re, sample_im, rate_re, rate_im, weight,
        input  ready
    );
    modport sink (
        input  valid, operation, bin_index, sample_re, sample_im, rate_re, rate_im, weight,
        output ready
    );
endinterface

interface cfb_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;

    modport source (output valid, out_re, out_im, input ready);
    modport sink   (input valid, out_re, out_im, output ready);
endinterface

interface cfb_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] leak_gain;

    modport source (output valid, leak_gain, input ready);
    modport sink   (input valid, leak_gain, output ready);
endinterface

`default_nettype wire

### design/cfb_cell.sv
// One bin of the resonator row: holds its phase, rate and weight.
// Depends on cfb_pkg; instantiated NUM_BINS times by the top level.
`default_nettype none

module cfb_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  cfb_pkg::ring_ctl_t ctl,
    input  logic               wr_rate,
    input  logic               wr_weight,
    input  cfb_pkg::coef_t     wr_coef,
    input  cfb_pkg::phase_t    phase_in,
    input  cfb_pkg::coef_t     coef_in,
    output cfb_pkg::phase_t    phase_out,
    output cfb_pkg::coef_t     coef_out
);

    cfb_pkg::phase_t phase_reg, phase_next;
    cfb_pkg::coef_t  coef_reg, coef_next;

    always_comb
    begin
        phase_next = ctl.shift ? phase_in : phase_reg;
    end

    always_comb
    begin
        coef_next = coef_reg;
        priority if (ctl.rotate)
        begin
            coef_next = coef_in;
        end
        else
        begin
            if (wr_rate)
            begin
                coef_next.rate_re = wr_coef.rate_re;
                coef_next.rate_im = wr_coef.rate_im;
            end
            if (wr_weight)
            begin
                coef_next.weight = wr_coef.weight;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            coef_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            coef_reg  <= coef_next;
        end
    end

    assign phase_out = phase_reg;
    assign coef_out  = coef_reg;

endmodule

`default_nettype wire

### design/cfb_update.sv
// Phase update pipeline: rate times phase plus leak times sample, rounded to Q8.24.
// Two register stages that close the phase ring of the cell row. Depends on cfb_pkg.
`default_nettype none

module cfb_update (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        leak_gain,
    input  logic signed [15:0] sample_re,
    input  logic signed [15:0] sample_im,
    input  logic               feed_valid,
    input  cfb_pkg::phase_t    head_phase,
    input  cfb_pkg::coef_t     head_coef,
    output cfb_pkg::upd_t      upd
);

    localparam logic signed [52:0] PH_RND = 53'sd65536;

    logic signed [32:0] leak_re_reg, leak_im_reg;

    logic signed [49:0] rr_reg, ii_reg, ri_reg, ir_reg;
    logic signed [15:0] w1_reg;
    logic               v1_reg;

    logic signed [52:0] sum_re, sum_im;
    logic signed [35:0] sh_re, sh_im;
    cfb_pkg::upd_t      upd_next;
    logic               upd_valid_reg;
    logic signed [15:0] upd_weight_reg;
    cfb_pkg::phase_t    upd_phase_reg;

    function automatic logic signed [31:0] sat_phase(input logic signed [35:0] x);
        logic signed [31:0] r;
        if ((&x[35:31]) || !(|x[35:31]))
            r = x[31:0];
        else if (x[35])
            r = 32'sh8000_0000;
        else
            r = 32'sh7fff_ffff;
        return r;
    endfunction

    // leak product, constant over one sweep
    always_ff @(posedge clk)
    begin
        leak_re_reg <= $signed({1'b0, leak_gain}) * sample_re;
        leak_im_reg <= $signed({1'b0, leak_gain}) * sample_im;
    end

    // stage 1: the four partial products of the complex multiply
    always_ff @(posedge clk)
    begin
        rr_reg <= head_coef.rate_re * head_phase.re;
        ii_reg <= head_coef.rate_im * head_phase.im;
        ri_reg <= head_coef.rate_re * head_phase.im;
        ir_reg <= head_coef.rate_im * head_phase.re;
        w1_reg <= head_coef.weight;
    end

    // stage 2: combine at 2^-41, round half up to 2^-24, saturate
    always_comb
    begin
        sum_re = 53'(rr_reg) - 53'(ii_reg) + (53'(leak_re_reg) <<< 10) + PH_RND;
        sum_im = 53'(ri_reg) + 53'(ir_reg) + (53'(leak_im_reg) <<< 10) + PH_RND;
        sh_re  = $signed(sum_re[52:17]);
        sh_im  = $signed(sum_im[52:17]);
        upd_next.valid    = v1_reg;
        upd_next.weight   = w1_reg;
        upd_next.phase.re = sat_phase(sh_re);
        upd_next.phase.im = sat_phase(sh_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            upd_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= feed_valid;
            upd_valid_reg <= upd_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        upd_weight_reg <= upd_next.weight;
        upd_phase_reg  <= upd_next.phase;
    end

    assign upd = '{valid: upd_valid_reg, weight: upd_weight_reg, phase: upd_phase_reg};

endmodule

`default_nettype wire

### design/cfb_accum.sv
// Weighted sum of the updated phases and final rounding to Q1.15.
// Depends on cfb_pkg; fed by cfb_update.
`default_nettype none

module cfb_accum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  cfb_pkg::upd_t      upd,
    output logic signed [15:0] out_re,
    output logic signed [15:0] out_im
);

    localparam logic signed [cfb_pkg::ACC_W:0] ACC_RND = (cfb_pkg::ACC_W + 1)'(25'sh80_0000);

    logic signed [47:0]             prod_re_reg, prod_im_reg;
    logic                           prod_valid_reg;
    logic signed [cfb_pkg::ACC_W-1:0] acc_re_reg, acc_im_reg;
    logic signed [cfb_pkg::ACC_W-1:0] acc_re_next, acc_im_next;
    logic signed [cfb_pkg::ACC_W:0]   rnd_re, rnd_im;
    logic signed [cfb_pkg::SH_W-1:0]  sh_re, sh_im;

    function automatic logic signed [15:0] sat_out(input logic signed [cfb_pkg::SH_W-1:0] x);
        logic signed [15:0] r;
        if ((&x[cfb_pkg::SH_W-1:15]) || !(|x[cfb_pkg::SH_W-1:15]))
            r = x[15:0];
        else if (x[cfb_pkg::SH_W-1])
            r = 16'sh8000;
        else
            r = 16'sh7fff;
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        prod_re_reg <= upd.weight * upd.phase.re;
        prod_im_reg <= upd.weight * upd.phase.im;
    end

    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        priority if (clear)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_re_next = acc_re_reg + cfb_pkg::ACC_W'(prod_re_reg);
            acc_im_next = acc_im_reg + cfb_pkg::ACC_W'(prod_im_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_re_reg     <= '0;
            acc_im_reg     <= '0;
        end
        else
        begin
            prod_valid_reg <= upd.valid;
            acc_re_reg     <= acc_re_next;
            acc_im_reg     <= acc_im_next;
        end
    end

    // round half up at 2^-15, then clamp to 16 bits
    always_comb
    begin
        rnd_re = (cfb_pkg::ACC_W + 1)'(acc_re_reg) + ACC_RND;
        rnd_im = (cfb_pkg::ACC_W + 1)'(acc_im_reg) + ACC_RND;
        sh_re  = $signed(rnd_re[cfb_pkg::ACC_W:24]);
        sh_im  = $signed(rnd_im[cfb_pkg::ACC_W:24]);
        out_re = sat_out(sh_re);
        out_im = sat_out(sh_im);
    end

endmodule

`default_nettype wire

### design/complex_resonator_filter_bank.sv
// Top level of the complex resonator bank: control, cell row, update and sum pipelines.
// Depends on cfb_pkg, cfb_if, cfb_cell, cfb_update and cfb_accum.
//
// Usage:
//   items   - valid/ready input channel. operation OP_SAMPLE runs one complex sample
//             through all bins and yields one transaction on results; OP_RATE and
//             OP_WEIGHT load one bin's rate or weight and yield nothing; the unused
//             code is taken and dropped.
//   results - valid/ready output channel with out_re/out_im, held in an output
//             register until taken.
//   cfg     - write channel for leak_gain, always ready; write only while idle.
// A sample sweeps the bins through one shared phase update, one bin a cycle, while
// the cell row shifts phases toward the head and circulates rates and weights.
// The result is formed by the sweep through the cell row and its 4-stage pipe (two
// update stages, the product register and the accumulator); the next item is taken
// only once the result is loaded into the output register, after the last sample.
// Reset clears all phases, rates and weights and sets leak_gain to 655. If results
// is stalled, a finished sweep waits for the output register to free before the
// next item is accepted; earlier results are never overwritten.
`default_nettype none

module complex_resonator_filter_bank (
    input  logic                clk,
    input  logic                rst_n,
    cfb_item_if.sink            items,
    cfb_result_if.source        results,
    cfb_cfg_if.sink             cfg
);

    localparam int N = cfb_pkg::NUM_BINS;

    cfb_pkg::state_t           state_reg, state_next;
    logic [cfb_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]               leak_reg;
    logic signed [15:0]        sample_re_reg, sample_im_reg;
    logic signed [15:0]        out_re_reg, out_im_reg;
    logic                      out_valid_reg, out_valid_next;

    logic                      item_ready;
    logic                      item_take;
    logic                      start;
    logic                      wr_rate_any, wr_weight_any;
    logic                      feed_valid;
    logic                      out_load;
    logic                      sweep_last;
    cfb_pkg::ring_ctl_t        ring_ctl;
    cfb_pkg::coef_t            wr_coef;

    cfb_pkg::phase_t           phase_q [N];
    cfb_pkg::coef_t            coef_q  [N];
    cfb_pkg::phase_t           phase_link [N];
    cfb_pkg::coef_t            coef_link  [N];
    logic [N-1:0]              wr_rate, wr_weight;

    cfb_pkg::upd_t             upd;
    logic signed [15:0]        sum_re, sum_im;

    assign item_take     = items.valid && item_ready;
    assign start         = item_take && (items.operation == cfb_pkg::OP_SAMPLE);
    assign wr_rate_any   = item_take && (items.operation == cfb_pkg::OP_RATE);
    assign wr_weight_any = item_take && (items.operation == cfb_pkg::OP_WEIGHT);
    assign sweep_last    = (cnt_reg == cfb_pkg::CNT_W'(N + 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            cfb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cfb_pkg::ST_RUN;
                    cnt_next   = '0;
                end
            end
            cfb_pkg::ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (sweep_last)
                    state_next = cfb_pkg::ST_DRAIN;
            end
            cfb_pkg::ST_DRAIN:
            begin
                state_next = cfb_pkg::ST_DONE;
            end
            cfb_pkg::ST_DONE:
            begin
                if (!out_valid_reg || results.ready)
                    state_next = cfb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cfb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        item_ready      = 1'b0;
        ring_ctl.shift  = 1'b0;
        ring_ctl.rotate = 1'b0;
        feed_valid      = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            cfb_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
            end
            cfb_pkg::ST_RUN:
            begin
                // ring of N cells plus two pipeline stages: N+2 shifts restore it
                ring_ctl.shift  = 1'b1;
                ring_ctl.rotate = (cnt_reg < cfb_pkg::CNT_W'(N));
                feed_valid      = (cnt_reg < cfb_pkg::CNT_W'(N));
            end
            cfb_pkg::ST_DRAIN:
            begin
            end
            cfb_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || results.ready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (out_load)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfb_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            leak_reg      <= cfb_pkg::LEAK_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                leak_reg <= cfg.leak_gain;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sample_re_reg <= items.sample_re;
            sample_im_reg <= items.sample_im;
        end
        if (out_load)
        begin
            out_re_reg <= sum_re;
            out_im_reg <= sum_im;
        end
    end

    assign wr_coef.rate_re = items.rate_re;
    assign wr_coef.rate_im = items.rate_im;
    assign wr_coef.weight  = items.weight;

    // cell row: phases move toward cell 0, the update result enters the tail;
    // coefficients circulate from cell 0 back to the tail
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        if (i == N - 1)
        begin : g_tail
            assign phase_link[i] = upd.phase;
            assign coef_link[i]  = coef_q[0];
        end
        else
        begin : g_body
            assign phase_link[i] = phase_q[i+1];
            assign coef_link[i]  = coef_q[i+1];
        end

        assign wr_rate[i]   = wr_rate_any && (int'(items.bin_index) == i);
        assign wr_weight[i] = wr_weight_any && (int'(items.bin_index) == i);

        cfb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ring_ctl),
            .wr_rate   (wr_rate[i]),
            .wr_weight (wr_weight[i]),
            .wr_coef   (wr_coef),
            .phase_in  (phase_link[i]),
            .coef_in   (coef_link[i]),
            .phase_out (phase_q[i]),
            .coef_out  (coef_q[i])
        );
    end

    cfb_update u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .leak_gain  (leak_reg),
        .sample_re  (sample_re_reg),
        .sample_im  (sample_im_reg),
        .feed_valid (feed_valid),
        .head_phase (phase_q[0]),
        .head_coef  (coef_q[0]),
        .upd        (upd)
    );

    cfb_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (start),
        .upd    (upd),
        .out_re (sum_re),
        .out_im (sum_im)
    );

    assign items.ready    = item_ready;
    assign cfg.ready      = 1'b1;
    assign results.valid  = out_valid_reg;
    assign results.out_re = out_re_reg;
    assign results.out_im = out_im_reg;

    // a new result only comes out of the end of a sweep
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == cfb_pkg::ST_DONE)
        else $error("result raised outside of sweep completion");

    // sweep counter never passes the last shift
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cfb_pkg::ST_RUN |-> cnt_reg <= cfb_pkg::CNT_W'(N + 1))
        else $error("sweep counter out of range");

    // a sweep only begins after a sample transaction
    a_run_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfb_pkg::ST_RUN && cnt_reg == '0) |-> $past(start))
        else $error("sweep started without a sample");

    // a finished sum waits while the output register is full and stalled
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfb_pkg::ST_DONE && out_valid_reg && !results.ready)
        |=> state_reg == cfb_pkg::ST_DONE)
        else $error("pending result overwritten");

    // no bin reaches the update pipe outside a sweep
    a_feed_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        upd.valid |-> $past(state_reg, 2) == cfb_pkg::ST_RUN)
        else $error("update pipe fed outside a sweep");

endmodule

`default_nettype wire
